[src/fra_pkg.sv]
// fra_pkg: shared constants for the fraction arithmetic block.
// Holds operation codes, default operand width and queue depth.
// No dependencies.
package fra_pkg;

  localparam int OPERAND_WIDTH = 31;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

endpackage

[src/fraction_arith_reduce.sv]
// fraction_arith_reduce: top level of the rational arithmetic unit.
// Depends on fra_pkg, fra_front, fra_queue, fra_back and fra_div.
//
// Usage:
//   Present an item on in_* with start high; it is taken at a clock edge
//   where busy is low. The front holds busy while one shared multiplier
//   forms the cross products, then hands the item to a two-entry queue,
//   so a new item can enter while the back still works. The back reduces
//   the fraction by binary GCD (one shift or subtract per cycle) and then
//   runs two or three divisions on one restoring divider. The time per
//   item is data dependent; an item with a zero denominator skips the
//   reduction and the divisions. The back sets the sustained rate.
//   Each result shows on out_* for exactly one cycle with out_strobe high;
//   the receiver cannot stall and must take it then.
//   Reset (rst_n low, synchronous) empties the queue and returns both
//   parts to idle; no memory needs clearing.
module fraction_arith_reduce #(
  parameter int OPERAND_WIDTH = fra_pkg::OPERAND_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_req_type,
  input  logic signed [OPERAND_WIDTH-1:0] in_num_a,
  input  logic signed [OPERAND_WIDTH-1:0] in_den_a,
  input  logic signed [OPERAND_WIDTH-1:0] in_num_b,
  input  logic signed [OPERAND_WIDTH-1:0] in_den_b,
  output logic                            out_strobe,
  output logic                            out_status,
  output logic signed [62:0]              out_res_num,
  output logic [60:0]                     out_res_den,
  output logic                            out_mixed_valid,
  output logic signed [62:0]              out_whole_part,
  output logic [59:0]                     out_remainder_part
);

  localparam int MW = 2 * OPERAND_WIDTH;
  localparam int QW = 2 + 2 * MW;

  logic          f_push, f_err, f_neg, q_full, q_empty, q_pop;
  logic [MW-1:0] f_magn, f_dmag;
  logic [QW-1:0] q_in, q_out;

  fra_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req_type (in_req_type),
    .in_num_a    (in_num_a),
    .in_den_a    (in_den_a),
    .in_num_b    (in_num_b),
    .in_den_b    (in_den_b),
    .q_full      (q_full),
    .q_push      (f_push),
    .q_err       (f_err),
    .q_neg       (f_neg),
    .q_magn      (f_magn),
    .q_dmag      (f_dmag)
  );

  assign q_in = {f_err, f_neg, f_magn, f_dmag};

  fra_queue #(.DATA_W(QW), .DEPTH(fra_pkg::QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  fra_back #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_pop              (q_pop),
    .q_err              (q_out[QW-1]),
    .q_neg              (q_out[QW-2]),
    .q_magn             (q_out[2*MW-1:MW]),
    .q_dmag             (q_out[MW-1:0]),
    .out_strobe         (out_strobe),
    .out_status         (out_status),
    .out_res_num        (out_res_num),
    .out_res_den        (out_res_den),
    .out_mixed_valid    (out_mixed_valid),
    .out_whole_part     (out_whole_part),
    .out_remainder_part (out_remainder_part)
  );

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for more than one cycle");

  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_status) |-> (out_res_den != '0))
    else $error("valid result with zero denominator");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status) |-> (out_res_num == '0 && out_res_den == '0
                                    && !out_mixed_valid))
    else $error("error result carries nonzero fields");

  a_mixed_den: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_mixed_valid) |-> (out_res_den != 61'd1))
    else $error("mixed split flagged with unit denominator");

endmodule

[src/fra_front.sv]
// fra_front: accepts an item, forms cross products on one shared multiplier
// and classifies zero denominators. Depends on fra_pkg.
module fra_front #(
  parameter int OPERAND_WIDTH = fra_pkg::OPERAND_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_req_type,
  input  logic signed [OPERAND_WIDTH-1:0] in_num_a,
  input  logic signed [OPERAND_WIDTH-1:0] in_den_a,
  input  logic signed [OPERAND_WIDTH-1:0] in_num_b,
  input  logic signed [OPERAND_WIDTH-1:0] in_den_b,
  input  logic                            q_full,
  output logic                            q_push,
  output logic                            q_err,
  output logic                            q_neg,
  output logic [2*OPERAND_WIDTH-1:0]      q_magn,
  output logic [2*OPERAND_WIDTH-1:0]      q_dmag
);

  localparam int PW = 2 * OPERAND_WIDTH;
  localparam int NW = PW + 1;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]                     state_r, state_nxt;
  logic [1:0]                     step_r, step_nxt;
  logic [1:0]                     op_r;
  logic                           zden_r;
  logic signed [OPERAND_WIDTH-1:0] n1_r, d1_r, n2_r, d2_r;
  logic signed [OPERAND_WIDTH-1:0] mx, my;
  logic signed [PW-1:0]           prod_r;
  logic signed [NW-1:0]           nr_r;
  logic signed [PW-1:0]           dr_r;
  logic signed [NW-1:0]           nr_abs, dr_ext, dr_abs;
  logic                           accept;

  assign busy   = (state_r != F_IDLE);
  assign accept = start && !busy;

  always_comb begin
    mx = n1_r;
    my = d2_r;
    unique case (step_r)
      2'd0: begin
        mx = n1_r;
        my = (op_r == fra_pkg::OP_MUL) ? n2_r : d2_r;
      end
      2'd1: begin
        mx = n2_r;
        my = (op_r == fra_pkg::OP_MUL || op_r == fra_pkg::OP_DIV) ? '0 : d1_r;
      end
      default: begin
        mx = d1_r;
        my = (op_r == fra_pkg::OP_DIV) ? n2_r : d2_r;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      F_IDLE: begin
        step_nxt = 2'd0;
        if (accept) state_nxt = F_MUL;
      end
      F_MUL: begin
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd3) state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      step_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_req_type;
      n1_r   <= in_num_a;
      d1_r   <= in_den_a;
      n2_r   <= in_num_b;
      d2_r   <= in_den_b;
      zden_r <= (in_den_a == '0) || (in_den_b == '0);
    end
    if (state_r == F_MUL) begin
      prod_r <= mx * my;
      unique case (step_r)
        2'd1: nr_r <= NW'(prod_r);
        2'd2: nr_r <= (op_r == fra_pkg::OP_SUB) ? nr_r - NW'(prod_r) : nr_r + NW'(prod_r);
        2'd3: dr_r <= prod_r;
        default: ;
      endcase
    end
  end

  assign dr_ext = NW'(dr_r);
  assign nr_abs = nr_r[NW-1] ? -nr_r : nr_r;
  assign dr_abs = dr_ext[NW-1] ? -dr_ext : dr_ext;

  assign q_push = (state_r == F_PUSH) && !q_full;
  assign q_err  = zden_r || (dr_r == '0);
  assign q_neg  = nr_r[NW-1] ^ dr_r[PW-1];
  assign q_magn = nr_abs[PW-1:0];
  assign q_dmag = dr_abs[PW-1:0];

endmodule

[src/fra_queue.sv]
// fra_queue: short first-in first-out queue between front and back.
// Depends on fra_pkg for the default depth.
module fra_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = fra_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              full,
  output logic              empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wp_r, rp_r;
  logic [CNT_W-1:0]  cnt_r;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

[src/fra_div.sv]
// fra_div: restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
module fra_div #(
  parameter int W = 62
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         go,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quo,
  output logic [W-1:0] rem
);

  localparam int CW = $clog2(W);

  logic [W:0]    r_r;
  logic [W-1:0]  q_r, d_r;
  logic [CW-1:0] cnt_r;
  logic          act_r, done_r;
  logic [W:0]    sh;

  assign sh   = {r_r[W-1:0], q_r[W-1]};
  assign done = done_r;
  assign quo  = q_r;
  assign rem  = r_r[W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        act_r <= 1'b1;
      end else if (act_r && cnt_r == CW'(W - 1)) begin
        act_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      r_r   <= '0;
      q_r   <= dividend;
      d_r   <= divisor;
      cnt_r <= '0;
    end else if (act_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (sh >= {1'b0, d_r}) begin
        r_r <= sh - {1'b0, d_r};
        q_r <= {q_r[W-2:0], 1'b1};
      end else begin
        r_r <= sh;
        q_r <= {q_r[W-2:0], 1'b0};
      end
    end
  end

endmodule

[src/fra_back.sv]
// fra_back: binary GCD reduction, divisions and mixed-number split.
// Depends on fra_pkg and fra_div.
module fra_back #(
  parameter int OPERAND_WIDTH = fra_pkg::OPERAND_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  output logic                       q_pop,
  input  logic                       q_err,
  input  logic                       q_neg,
  input  logic [2*OPERAND_WIDTH-1:0] q_magn,
  input  logic [2*OPERAND_WIDTH-1:0] q_dmag,
  output logic                       out_strobe,
  output logic                       out_status,
  output logic signed [62:0]         out_res_num,
  output logic [60:0]                out_res_den,
  output logic                       out_mixed_valid,
  output logic signed [62:0]         out_whole_part,
  output logic [59:0]                out_remainder_part
);

  localparam int MW = 2 * OPERAND_WIDTH;
  localparam int KW = $clog2(MW + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TWO  = 4'd1;
  localparam logic [3:0] S_LOOP = 4'd2;
  localparam logic [3:0] S_QA   = 4'd3;
  localparam logic [3:0] S_WA   = 4'd4;
  localparam logic [3:0] S_QB   = 4'd5;
  localparam logic [3:0] S_WB   = 4'd6;
  localparam logic [3:0] S_CHK  = 4'd7;
  localparam logic [3:0] S_WC   = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]    state_r;
  logic          err_r, neg_r, mix_r;
  logic [MW-1:0] magn_r, dmag_r, u_r, v_r, g_r, rn_r, rd_r, wq_r, wr_r;
  logic [KW-1:0] k_r;
  logic          div_go, div_done;
  logic [MW-1:0] div_a, div_b, div_q, div_r;
  logic signed [MW:0] num_s, whole_s;

  assign q_pop = (state_r == S_IDLE) && !q_empty;

  always_comb begin
    div_go = 1'b0;
    div_a  = magn_r;
    div_b  = g_r;
    unique case (state_r)
      S_QA: div_go = 1'b1;
      S_QB: begin
        div_go = 1'b1;
        div_a  = dmag_r;
      end
      S_CHK: begin
        div_go = (rn_r >= rd_r) && (rd_r != MW'(1));
        div_a  = rn_r;
        div_b  = rd_r;
      end
      default: ;
    endcase
  end

  fra_div #(.W(MW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quo      (div_q),
    .rem      (div_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            if (q_err)            state_r <= S_OUT;
            else if (q_magn == '0) state_r <= S_QA;
            else                  state_r <= S_TWO;
          end
        end
        S_TWO:  if (u_r[0] || v_r[0]) state_r <= S_LOOP;
        S_LOOP: if (u_r == '0) state_r <= S_QA;
        S_QA:   state_r <= S_WA;
        S_WA:   if (div_done) state_r <= S_QB;
        S_QB:   state_r <= S_WB;
        S_WB:   if (div_done) state_r <= S_CHK;
        S_CHK:  state_r <= div_go ? S_WC : S_OUT;
        S_WC:   if (div_done) state_r <= S_OUT;
        S_OUT:  state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        err_r  <= q_err;
        neg_r  <= q_neg;
        magn_r <= q_magn;
        dmag_r <= q_dmag;
        u_r    <= q_magn;
        v_r    <= q_dmag;
        g_r    <= q_dmag;
        k_r    <= '0;
        mix_r  <= 1'b0;
      end
      S_TWO: begin
        if (!u_r[0] && !v_r[0]) begin
          u_r <= u_r >> 1;
          v_r <= v_r >> 1;
          k_r <= k_r + 1'b1;
        end
      end
      S_LOOP: begin
        priority if (u_r == '0) begin
          g_r <= v_r << k_r;
        end else if (!u_r[0]) begin
          u_r <= u_r >> 1;
        end else if (!v_r[0]) begin
          v_r <= v_r >> 1;
        end else if (u_r >= v_r) begin
          u_r <= u_r - v_r;
        end else begin
          v_r <= v_r - u_r;
        end
      end
      S_WA: if (div_done) rn_r <= div_q;
      S_WB: if (div_done) rd_r <= div_q;
      S_WC: begin
        if (div_done) begin
          mix_r <= 1'b1;
          wq_r  <= div_q;
          wr_r  <= div_r;
        end
      end
      default: ;
    endcase
  end

  assign num_s   = neg_r ? -(MW+1)'(rn_r) : (MW+1)'(rn_r);
  assign whole_s = neg_r ? -(MW+1)'(wq_r) : (MW+1)'(wq_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= (state_r == S_OUT);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT) begin
      out_status         <= err_r;
      out_res_num        <= err_r ? '0 : 63'(num_s);
      out_res_den        <= err_r ? '0 : 61'(rd_r);
      out_mixed_valid    <= !err_r && mix_r;
      out_whole_part     <= (!err_r && mix_r) ? 63'(whole_s) : '0;
      out_remainder_part <= (!err_r && mix_r) ? 60'(wr_r) : '0;
    end
  end

endmodule
